/* rtl/lscsm_pkg.sv */
// Package with the transaction types and field codes of the line scanner control machine.
package lscsm_pkg;

   typedef struct packed {
      logic       host_pcf_valid;
      logic [3:0] host_pcf;
      logic       host_data_valid;
      logic [7:0] host_data;
      logic       host_data_read;
      logic       level2_busy;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] pcf_now;
      logic [7:0] scf_now;
      logic [7:0] pdf_now;
      logic [7:0] sdf_now;
      logic [1:0] line_mode;
      logic       data_full;
      logic       irq_level2;
      logic       rx_taken;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [3:0] tx_phase;
      logic       tx_frame_end;
   } rsp_type;

   localparam logic [1:0] LS_RESET = 2'd0;
   localparam logic [1:0] LS_TX    = 2'd1;
   localparam logic [1:0] LS_RX    = 2'd2;

   localparam logic [3:0] LC_SDLC8  = 4'd8;
   localparam logic [3:0] LC_SDLC9  = 4'd9;
   localparam logic [3:0] LC_BSC    = 4'hC;
   localparam logic [3:0] LC_RESET  = 4'd9;

   localparam logic [3:0] PCF_IDLE     = 4'h0;
   localparam logic [3:0] PCF_SET1     = 4'h1;
   localparam logic [3:0] PCF_SET2     = 4'h2;
   localparam logic [3:0] PCF_SET3     = 4'h3;
   localparam logic [3:0] PCF_HUNT4    = 4'h4;
   localparam logic [3:0] PCF_HUNT5    = 4'h5;
   localparam logic [3:0] PCF_FLAG     = 4'h6;
   localparam logic [3:0] PCF_RECV     = 4'h7;
   localparam logic [3:0] PCF_TX_INIT  = 4'h8;
   localparam logic [3:0] PCF_TX_NORM  = 4'h9;
   localparam logic [3:0] PCF_TX_ALT   = 4'hA;
   localparam logic [3:0] PCF_TURN     = 4'hC;
   localparam logic [3:0] PCF_MONITOR  = 4'hD;
   localparam logic [3:0] PCF_DISABLE  = 4'hF;

   localparam logic [7:0] SCF_SERVICE  = 8'h40;
   localparam logic [7:0] SCF_DCD      = 8'h08;
   localparam logic [7:0] SCF_FLAG     = 8'h04;
   localparam logic [7:0] SCF_KEEP     = 8'h4A;
   localparam logic [7:0] SCF_END      = 8'h44;
   localparam logic [7:0] SDF_SYNC     = 8'h04;

   localparam logic [7:0] BYTE_SYN     = 8'h32;
   localparam logic [7:0] BYTE_FLAG    = 8'h7E;
   localparam logic [7:0] BYTE_END1    = 8'h47;
   localparam logic [7:0] BYTE_END2    = 8'h0F;
   localparam logic [7:0] BYTE_FILL    = 8'hFF;

endpackage

/* rtl/line_scanner_control_state_machine.sv */
// Top level of the line scanner control machine: one scan tick per request transaction.
//
// Each request transaction on req_ is one scan tick for the line: host control
// field and data writes, the host data read, the level 2 busy flag and a received
// byte. It produces exactly one response transaction on rsp_ with the updated
// control, data and serial fields, the line state, the interrupt request, the
// byte-taken flag and any byte sent to the line.
// The tick is decided by combinational logic on the state registers and the request,
// and the result lands in the response register: the response appears in the cycle
// after acceptance, and a new request is accepted in every cycle in which req_stall
// is low. Outside reset, req_stall rises only while the response register holds a
// result that the receiver stalls, so stalls on rsp_ hold the input side as well.
// The csr_ channel writes the 4-bit line code; it is always ready and also
// clears the forced SDLC mode. Writes are expected only while no tick is open.
// Synchronous reset clears all fields, sets the line code to 9 and empties the
// response register; req_stall is high during reset.
module line_scanner_control_state_machine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lscsm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lscsm_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);

   logic [3:0] line_code_ff;
   logic [3:0] pcf_cur_ff, pcf_prev_ff, pcf_next_ff;
   logic [7:0] scf_ff, pdf_ff, sdf_ff;
   logic [1:0] line_state_ff;
   logic       data_full_ff;
   logic [7:0] rx_hist_1_ff, rx_hist_2_ff;
   logic [7:0] last_tx_ff;
   logic       sdlc_forced_ff;
   logic       rsp_valid_ff;
   lscsm_pkg::rsp_type rsp_ff;

   logic [3:0] pcf_cur_in, pcf_prev_in, pcf_next_in;
   logic [7:0] scf_in, pdf_in, sdf_in;
   logic [1:0] line_state_in;
   logic       data_full_in;
   logic [7:0] rx_hist_1_in, rx_hist_2_in;
   logic [7:0] last_tx_in;
   logic       sdlc_forced_in;
   lscsm_pkg::rsp_type rsp_in;

   logic       accept;
   logic [3:0] lcd;
   logic       bsc;
   logic       first;
   logic       eflag;
   logic       irq, taken, txv, fend;
   logic [7:0] txb;
   logic [3:0] txph;

   assign req_stall   = reset || (rsp_valid_ff && rsp_stall);
   assign accept      = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign lcd = sdlc_forced_ff ? lscsm_pkg::LC_SDLC9 : line_code_ff;
   assign bsc = (lcd == lscsm_pkg::LC_BSC);

   always_comb begin
      scf_in         = scf_ff;
      pdf_in         = pdf_ff;
      sdf_in         = sdf_ff;
      line_state_in  = line_state_ff;
      data_full_in   = data_full_ff;
      rx_hist_1_in   = rx_hist_1_ff;
      rx_hist_2_in   = rx_hist_2_ff;
      last_tx_in     = last_tx_ff;
      sdlc_forced_in = sdlc_forced_ff;
      pcf_next_in    = pcf_next_ff;
      pcf_cur_in     = pcf_cur_ff;
      pcf_prev_in    = pcf_prev_ff;
      irq   = 1'b0;
      taken = 1'b0;
      txv   = 1'b0;
      fend  = 1'b0;
      txb   = 8'h00;
      txph  = 4'h0;
      eflag = 1'b0;

      if (req_payload.host_data_read) begin
         data_full_in = 1'b0;
         scf_in = scf_in & ~lscsm_pkg::SCF_SERVICE;
      end
      if (req_payload.host_data_valid) begin
         pdf_in = req_payload.host_data;
         data_full_in = 1'b1;
         scf_in = scf_in & ~lscsm_pkg::SCF_SERVICE;
      end
      if (req_payload.host_pcf_valid) begin
         pcf_next_in = req_payload.host_pcf;
      end

      scf_in = scf_in | lscsm_pkg::SCF_DCD;
      if (pcf_cur_in != pcf_next_in) begin
         if (pcf_next_in == lscsm_pkg::PCF_IDLE) begin
            line_state_in = lscsm_pkg::LS_RESET;
         end
         pcf_prev_in = pcf_cur_in;
         pcf_cur_in = pcf_next_in;
      end
      first = (pcf_prev_in != pcf_cur_in);

      unique case (pcf_cur_in)
         lscsm_pkg::PCF_IDLE: begin
            scf_in = scf_in & lscsm_pkg::SCF_KEEP;
         end
         lscsm_pkg::PCF_SET1, lscsm_pkg::PCF_SET2, lscsm_pkg::PCF_SET3: begin
            if (first) begin
               scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
               pcf_next_in = lscsm_pkg::PCF_IDLE;
               irq = 1'b1;
            end
         end
         lscsm_pkg::PCF_HUNT4, lscsm_pkg::PCF_HUNT5: begin
            rx_hist_1_in = 8'h00;
            rx_hist_2_in = 8'h00;
            if (line_state_in != lscsm_pkg::LS_RESET && line_state_in != lscsm_pkg::LS_TX) begin
               if (bsc && req_payload.rx_valid) begin
                  taken = 1'b1;
                  if (req_payload.rx_byte == lscsm_pkg::BYTE_SYN) begin
                     pdf_in = req_payload.rx_byte;
                     pcf_next_in = lscsm_pkg::PCF_RECV;
                     sdf_in = sdf_in | lscsm_pkg::SDF_SYNC;
                  end
               end
               if (lcd == lscsm_pkg::LC_SDLC8 || lcd == lscsm_pkg::LC_SDLC9) begin
                  scf_in = scf_in & ~lscsm_pkg::SCF_FLAG;
                  if (req_payload.rx_valid) begin
                     taken = 1'b1;
                     if (req_payload.rx_byte == lscsm_pkg::BYTE_FLAG) begin
                        scf_in = scf_in | lscsm_pkg::SCF_FLAG;
                        sdlc_forced_in = 1'b1;
                        pcf_next_in = lscsm_pkg::PCF_FLAG;
                        irq = 1'b1;
                     end
                  end
               end
            end
         end
         lscsm_pkg::PCF_FLAG: begin
            if (!req_payload.level2_busy && req_payload.rx_valid) begin
               taken = 1'b1;
               pdf_in = req_payload.rx_byte;
               rx_hist_2_in = rx_hist_1_in;
               rx_hist_1_in = req_payload.rx_byte;
               if (req_payload.rx_byte != lscsm_pkg::BYTE_FLAG) begin
                  scf_in = (scf_in | lscsm_pkg::SCF_SERVICE) & ~lscsm_pkg::SCF_FLAG;
                  data_full_in = 1'b1;
                  pcf_next_in = lscsm_pkg::PCF_RECV;
                  irq = 1'b1;
               end
            end
         end
         lscsm_pkg::PCF_RECV: begin
            if (!req_payload.level2_busy) begin
               if (bsc && (scf_in & lscsm_pkg::SCF_SERVICE) == 8'h00) begin
                  if (req_payload.rx_valid) begin
                     taken = 1'b1;
                     pdf_in = req_payload.rx_byte;
                  end else begin
                     pdf_in = lscsm_pkg::BYTE_FILL;
                  end
                  scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
                  pcf_next_in = lscsm_pkg::PCF_RECV;
                  irq = 1'b1;
               end
               if (lcd == lscsm_pkg::LC_SDLC9 && !data_full_in && req_payload.rx_valid) begin
                  eflag = (rx_hist_2_in == lscsm_pkg::BYTE_END1) &&
                          (rx_hist_1_in == lscsm_pkg::BYTE_END2) &&
                          (req_payload.rx_byte == lscsm_pkg::BYTE_FLAG);
                  taken = 1'b1;
                  pdf_in = req_payload.rx_byte;
                  rx_hist_2_in = rx_hist_1_in;
                  rx_hist_1_in = req_payload.rx_byte;
                  if (eflag) begin
                     line_state_in = lscsm_pkg::LS_TX;
                     scf_in = scf_in | lscsm_pkg::SCF_END;
                     pcf_next_in = lscsm_pkg::PCF_FLAG;
                  end else begin
                     data_full_in = 1'b1;
                     scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
                     pcf_next_in = lscsm_pkg::PCF_RECV;
                  end
                  irq = 1'b1;
               end
            end
         end
         lscsm_pkg::PCF_TX_INIT: begin
            if (!req_payload.level2_busy) begin
               if (bsc) begin
                  txb = ((scf_in & lscsm_pkg::SCF_SERVICE) == 8'h00) ? pdf_in : last_tx_in;
                  txv = 1'b1;
                  txph = lscsm_pkg::PCF_TX_INIT;
                  last_tx_in = txb;
                  data_full_in = 1'b0;
                  scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
                  pcf_next_in = lscsm_pkg::PCF_TX_NORM;
                  irq = 1'b1;
               end
               if (lcd == lscsm_pkg::LC_SDLC9) begin
                  scf_in = scf_in & ~lscsm_pkg::SCF_FLAG;
                  pcf_next_in = lscsm_pkg::PCF_TX_NORM;
               end
            end
         end
         lscsm_pkg::PCF_TX_NORM, lscsm_pkg::PCF_TX_ALT: begin
            if (!req_payload.level2_busy) begin
               if (bsc && (scf_in & lscsm_pkg::SCF_SERVICE) == 8'h00) begin
                  txb = pdf_in;
                  txv = 1'b1;
                  txph = pcf_cur_in;
                  last_tx_in = txb;
                  data_full_in = 1'b0;
                  scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
                  pcf_next_in = pcf_cur_in;
                  irq = 1'b1;
               end
               if (pcf_cur_in == lscsm_pkg::PCF_TX_NORM && lcd == lscsm_pkg::LC_SDLC9 &&
                   data_full_in) begin
                  txb = pdf_in;
                  txv = 1'b1;
                  txph = lscsm_pkg::PCF_TX_NORM;
                  last_tx_in = txb;
                  data_full_in = 1'b0;
                  scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
                  pcf_next_in = lscsm_pkg::PCF_TX_NORM;
                  irq = 1'b1;
               end
            end
         end
         lscsm_pkg::PCF_TURN: begin
            if (first) begin
               if (bsc) begin
                  txb = pdf_in;
                  txv = 1'b1;
                  txph = lscsm_pkg::PCF_TURN;
                  last_tx_in = txb;
                  line_state_in = lscsm_pkg::LS_RX;
                  scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
                  pcf_next_in = lscsm_pkg::PCF_HUNT5;
                  irq = 1'b1;
               end
               if (lcd == lscsm_pkg::LC_SDLC9) begin
                  fend = 1'b1;
                  line_state_in = lscsm_pkg::LS_RX;
                  scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
                  pcf_next_in = lscsm_pkg::PCF_HUNT5;
                  irq = 1'b1;
               end
            end
         end
         lscsm_pkg::PCF_MONITOR: begin
            if (bsc) begin
               pcf_next_in = lscsm_pkg::PCF_HUNT5;
               irq = 1'b1;
            end
         end
         lscsm_pkg::PCF_DISABLE: begin
            scf_in = scf_in | lscsm_pkg::SCF_SERVICE;
            pcf_next_in = lscsm_pkg::PCF_IDLE;
            irq = 1'b1;
         end
         default: begin
         end
      endcase

      pcf_prev_in = pcf_cur_in;
      pcf_cur_in = pcf_next_in;

      rsp_in.pcf_now      = pcf_cur_in;
      rsp_in.scf_now      = scf_in;
      rsp_in.pdf_now      = pdf_in;
      rsp_in.sdf_now      = sdf_in;
      rsp_in.line_mode    = line_state_in;
      rsp_in.data_full    = data_full_in;
      rsp_in.irq_level2   = irq;
      rsp_in.rx_taken     = taken;
      rsp_in.tx_valid     = txv;
      rsp_in.tx_byte      = txb;
      rsp_in.tx_phase     = txph;
      rsp_in.tx_frame_end = fend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_code_ff   <= lscsm_pkg::LC_RESET;
         pcf_cur_ff     <= 4'h0;
         pcf_prev_ff    <= 4'h0;
         pcf_next_ff    <= 4'h0;
         scf_ff         <= 8'h00;
         pdf_ff         <= 8'h00;
         sdf_ff         <= 8'h00;
         line_state_ff  <= lscsm_pkg::LS_RESET;
         data_full_ff   <= 1'b0;
         rx_hist_1_ff   <= 8'h00;
         rx_hist_2_ff   <= 8'h00;
         last_tx_ff     <= 8'h00;
         sdlc_forced_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            pcf_cur_ff     <= pcf_cur_in;
            pcf_prev_ff    <= pcf_prev_in;
            pcf_next_ff    <= pcf_next_in;
            scf_ff         <= scf_in;
            pdf_ff         <= pdf_in;
            sdf_ff         <= sdf_in;
            line_state_ff  <= line_state_in;
            data_full_ff   <= data_full_in;
            rx_hist_1_ff   <= rx_hist_1_in;
            rx_hist_2_ff   <= rx_hist_2_in;
            last_tx_ff     <= last_tx_in;
         end
         if (csr_valid && csr_ready) begin
            line_code_ff   <= csr_data;
            sdlc_forced_ff <= 1'b0;
         end else if (accept) begin
            sdlc_forced_ff <= sdlc_forced_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // Every accepted tick must leave a response in the output register.
   a_tick_gives_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no response");

   // The control field latch and the field in force agree between ticks.
   a_pcf_latch_agrees: assert property (@(posedge clock) disable iff (reset)
      pcf_cur_ff == pcf_next_ff)
      else $error("next control field differs from current between ticks");

   // A byte can only be taken when one was offered.
   a_taken_needs_byte: assert property (@(posedge clock) disable iff (reset)
      accept && !req_payload.rx_valid |=> !rsp_ff.rx_taken)
      else $error("byte taken without an offered byte");

   // Transmit byte and phase are zero when nothing is sent.
   a_tx_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.tx_valid |-> rsp_ff.tx_byte == 8'h00 && rsp_ff.tx_phase == 4'h0)
      else $error("transmit fields not cleared without a transmit byte");

   // The line state never takes the unused code.
   a_line_state_legal: assert property (@(posedge clock) disable iff (reset)
      line_state_ff != 2'd3)
      else $error("line state holds the unused code");

endmodule
